// File: design/asrc_pkg.sv
// shared types, constants and helpers for the abs slip release controller
package asrc_pkg;

  localparam int MaxPresets = 3;

  localparam int ACC_W    = 21;
  localparam int LIMIT_W  = 15;
  localparam int SLIP_W   = 16;
  localparam int SPEED_W  = 16;
  localparam int PERIOD_W = 20;
  localparam int IDX_W    = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // speed above 20 km/h: speed_q8 * 36 > 51200
  localparam int SCALED_W = 22;
  localparam logic [SCALED_W-1:0] SPEED_MUL    = 22'd36;
  localparam logic [SCALED_W-1:0] SPEED_THRESH = 22'd51200;

  localparam logic [LIMIT_W-1:0] BASE_LIMIT_RESET = 15'd819;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 20'd50000;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_CYCLE = 1'b1;

  localparam logic [1:0] CHAN_ALL   = 2'd0;
  localparam logic [1:0] CHAN_PAIRS = 2'd1;
  localparam logic [1:0] CHAN_EACH  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UNIT_PRESENT = 4'd0,
    REG_CHANNEL_MODE = 4'd1,
    REG_PERIOD_US    = 4'd2,
    REG_PRESET_COUNT = 4'd3,
    REG_BASE_LIMIT   = 4'd4,
    REG_PRESET_0     = 4'd5,
    REG_PRESET_1     = 4'd6,
    REG_PRESET_2     = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic               active;
    logic [IDX_W-1:0]   idx;
    logic [LIMIT_W-1:0] limit;
  } step_state_t;

  // (v mod n) for v up to 4 and n from 1 to 3
  function automatic logic [IDX_W-1:0] step_wrap(input logic [2:0] v,
                                                 input logic [1:0] n);
    logic [IDX_W-1:0] r;
    case (n)
      2'd1: r = '0;
      2'd2: r = {1'b0, v[0]};
      2'd3: r = (v >= 3'd3) ? IDX_W'(v - 3'd3) : IDX_W'(v);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] eff_count(input logic [1:0] count);
    return (count < 2'(MaxPresets)) ? count : 2'(MaxPresets);
  endfunction

endpackage

// File: design/asrc_stepper.sv
// preset stepper: next activity, preset index and slip limit for a cycle word
module asrc_stepper (
  input  logic                          unit_present,
  input  logic [1:0]                    count,
  input  logic                          step_up,
  input  logic [asrc_pkg::LIMIT_W-1:0]  preset_0,
  input  logic [asrc_pkg::LIMIT_W-1:0]  preset_1,
  input  logic [asrc_pkg::LIMIT_W-1:0]  preset_2,
  input  asrc_pkg::step_state_t         cur,
  output asrc_pkg::step_state_t         nxt
);

  logic [1:0]                   n;
  logic [asrc_pkg::IDX_W-1:0]   idx_new;
  logic                         load_limit;
  logic [asrc_pkg::LIMIT_W-1:0] pv;

  assign n = asrc_pkg::eff_count(count);

  always_comb begin
    case (idx_new)
      2'd0: pv = preset_0;
      2'd1: pv = preset_1;
      2'd2: pv = preset_2;
      default: pv = '0;
    endcase
  end

  always_comb begin
    nxt = cur;
    idx_new = cur.idx;
    load_limit = 1'b0;
    if (unit_present) begin
      if (n == 2'd0) begin
        nxt.active = ~cur.active;
      end else if (cur.active) begin
        if (step_up) begin
          idx_new = asrc_pkg::step_wrap({1'b0, cur.idx} + 3'd1, n);
          nxt.idx = idx_new;
          // wrapping past the last preset turns the unit off
          if (idx_new == '0) begin
            nxt.active = 1'b0;
          end else begin
            load_limit = 1'b1;
          end
        end else begin
          if (cur.idx == '0) begin
            nxt.active = 1'b0;
          end else begin
            idx_new = cur.idx - 2'd1;
            nxt.idx = idx_new;
            load_limit = 1'b1;
          end
        end
      end else begin
        nxt.active = 1'b1;
        idx_new = step_up ? '0 : n - 2'd1;
        nxt.idx = idx_new;
        load_limit = 1'b1;
      end
    end
    if (load_limit) begin
      nxt.limit = pv;
    end
  end

endmodule

// File: design/asrc_release.sv
// slip threshold compare and wheel grouping for one update
module asrc_release (
  input  logic                                active,
  input  logic [1:0]                          channel_mode,
  input  logic [asrc_pkg::LIMIT_W-1:0]        limit,
  input  logic [asrc_pkg::SPEED_W-1:0]        speed_q8,
  input  logic signed [asrc_pkg::SLIP_W-1:0]  slip_front_left,
  input  logic signed [asrc_pkg::SLIP_W-1:0]  slip_front_right,
  input  logic signed [asrc_pkg::SLIP_W-1:0]  slip_rear_left,
  input  logic signed [asrc_pkg::SLIP_W-1:0]  slip_rear_right,
  input  logic [3:0]                          cur_mask,
  output logic [3:0]                          new_mask
);

  logic [asrc_pkg::SCALED_W-1:0]    speed_scaled;
  logic                             fast;
  logic signed [asrc_pkg::SLIP_W:0] lim_neg;
  logic [3:0]                       rel;

  assign speed_scaled = asrc_pkg::SCALED_W'(speed_q8) * asrc_pkg::SPEED_MUL;
  assign fast = speed_scaled > asrc_pkg::SPEED_THRESH;
  assign lim_neg = -$signed({2'b00, limit});

  // a wheel wants release when its slip is strictly below minus the limit
  assign rel[0] = $signed({slip_front_left[15], slip_front_left}) < lim_neg;
  assign rel[1] = $signed({slip_front_right[15], slip_front_right}) < lim_neg;
  assign rel[2] = $signed({slip_rear_left[15], slip_rear_left}) < lim_neg;
  assign rel[3] = $signed({slip_rear_right[15], slip_rear_right}) < lim_neg;

  always_comb begin
    new_mask = 4'hF;
    if (active && fast) begin
      case (channel_mode)
        asrc_pkg::CHAN_ALL:   new_mask = (|rel) ? 4'h0 : 4'hF;
        asrc_pkg::CHAN_PAIRS: new_mask = {{2{~(rel[2] | rel[3])}},
                                          {2{~(rel[0] | rel[1])}}};
        asrc_pkg::CHAN_EACH:  new_mask = ~rel;
        default:              new_mask = cur_mask;
      endcase
    end
  end

endmodule

// File: design/abs_slip_release_controller.sv
// top level: input register, state update and result register
//
//  channel | handshake              | payload
//  in      | in_valid / in_ready    | kind, elapsed_us, speed_q8, four slips, step_up
//  out     | out_valid / out_ready  | release_mask, updated, active_now, mode_number,
//          |                        | mode_total, limit_now
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one word per cycle unless the result register is held; a taken word waits in the
// input register and state is updated in the cycle it moves to the result register
// the input register refills in the same cycle it drains, so stalls back up only
// when the result register is held; cfg is always ready
// synchronous reset clears the handshake state and loads the reset state
module abs_slip_release_controller (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic [15:0]                         elapsed_us,
  input  logic [15:0]                         speed_q8,
  input  logic signed [15:0]                  slip_front_left,
  input  logic signed [15:0]                  slip_front_right,
  input  logic signed [15:0]                  slip_rear_left,
  input  logic signed [15:0]                  slip_rear_right,
  input  logic                                step_up,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [3:0]                          release_mask,
  output logic                                updated,
  output logic                                active_now,
  output logic [1:0]                          mode_number,
  output logic [1:0]                          mode_total,
  output logic [14:0]                         limit_now,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [asrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [asrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // configuration
  logic                           unit_present;
  logic [1:0]                     channel_mode;
  logic [asrc_pkg::PERIOD_W-1:0]  period_us;
  logic [1:0]                     preset_count;
  logic [asrc_pkg::LIMIT_W-1:0]   preset_limit [3];

  // block state
  logic [asrc_pkg::ACC_W-1:0]     acc;
  logic [asrc_pkg::ACC_W-1:0]     acc_next;
  asrc_pkg::step_state_t          st;
  asrc_pkg::step_state_t          st_next;
  logic [3:0]                     mask;
  logic [3:0]                     mask_next;

  // input register
  logic                           s1_valid;
  logic                           s1_kind;
  logic [15:0]                    s1_elapsed;
  logic [15:0]                    s1_speed;
  logic signed [15:0]             s1_slip [4];
  logic                           s1_up;
  logic                           s1_fire;
  logic                           in_fire;

  // update logic
  asrc_pkg::step_state_t          step_nxt;
  logic [3:0]                     rel_mask;
  logic [asrc_pkg::ACC_W:0]       acc_sum;
  logic [asrc_pkg::ACC_W-1:0]     acc_sat;
  logic                           reach;
  logic                           upd;
  logic                           tick_active;
  logic [1:0]                     n_eff;
  logic [1:0]                     num;
  logic [1:0]                     tot;
  logic                           cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign s1_fire   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_fire;
  assign in_fire   = in_valid && in_ready;
  assign n_eff     = asrc_pkg::eff_count(preset_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_present    <= 1'b1;
      channel_mode    <= asrc_pkg::CHAN_ALL;
      period_us       <= asrc_pkg::PERIOD_RESET;
      preset_count    <= 2'd0;
      preset_limit[0] <= '0;
      preset_limit[1] <= '0;
      preset_limit[2] <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        asrc_pkg::REG_UNIT_PRESENT: unit_present    <= cfg_data[0];
        asrc_pkg::REG_CHANNEL_MODE: channel_mode    <= cfg_data[1:0];
        asrc_pkg::REG_PERIOD_US:    period_us       <= cfg_data;
        asrc_pkg::REG_PRESET_COUNT: preset_count    <= cfg_data[1:0];
        asrc_pkg::REG_PRESET_0:     preset_limit[0] <= cfg_data[14:0];
        asrc_pkg::REG_PRESET_1:     preset_limit[1] <= cfg_data[14:0];
        asrc_pkg::REG_PRESET_2:     preset_limit[2] <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind    <= kind;
      s1_elapsed <= elapsed_us;
      s1_speed   <= speed_q8;
      s1_slip[0] <= slip_front_left;
      s1_slip[1] <= slip_front_right;
      s1_slip[2] <= slip_rear_left;
      s1_slip[3] <= slip_rear_right;
      s1_up      <= step_up;
    end
  end

  asrc_stepper u_stepper (
    .unit_present (unit_present),
    .count        (preset_count),
    .step_up      (s1_up),
    .preset_0     (preset_limit[0]),
    .preset_1     (preset_limit[1]),
    .preset_2     (preset_limit[2]),
    .cur          (st),
    .nxt          (step_nxt)
  );

  assign tick_active = st.active && unit_present;

  asrc_release u_release (
    .active           (tick_active),
    .channel_mode     (channel_mode),
    .limit            (st.limit),
    .speed_q8         (s1_speed),
    .slip_front_left  (s1_slip[0]),
    .slip_front_right (s1_slip[1]),
    .slip_rear_left   (s1_slip[2]),
    .slip_rear_right  (s1_slip[3]),
    .cur_mask         (mask),
    .new_mask         (rel_mask)
  );

  // saturating time accumulator
  assign acc_sum = {1'b0, acc} + (asrc_pkg::ACC_W + 1)'(s1_elapsed);
  assign acc_sat = acc_sum[asrc_pkg::ACC_W] ? asrc_pkg::ACC_MAX
                                            : acc_sum[asrc_pkg::ACC_W-1:0];
  assign reach   = acc_sat >= asrc_pkg::ACC_W'(period_us);

  always_comb begin
    acc_next  = acc;
    st_next   = st;
    mask_next = mask;
    upd       = 1'b0;
    if (s1_kind == asrc_pkg::KIND_CYCLE) begin
      st_next = step_nxt;
    end else begin
      acc_next = acc_sat;
      if (reach) begin
        upd            = 1'b1;
        acc_next       = '0;
        st_next.active = tick_active;
        mask_next      = rel_mask;
      end
    end
  end

  always_comb begin
    if (!st_next.active) begin
      num = 2'd0;
      tot = 2'd0;
    end else if (n_eff == 2'd0) begin
      num = 2'd1;
      tot = 2'd1;
    end else begin
      num = st_next.idx + 2'd1;
      tot = n_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      st.active <= 1'b1;
      st.idx    <= '0;
      st.limit  <= asrc_pkg::BASE_LIMIT_RESET;
      mask      <= 4'hF;
    end else begin
      if (s1_fire) begin
        acc       <= acc_next;
        st.active <= st_next.active;
        st.idx    <= st_next.idx;
        mask      <= mask_next;
      end
      // a base limit write reloads the limit in use
      if (cfg_fire && cfg_index == asrc_pkg::REG_BASE_LIMIT) begin
        st.limit <= cfg_data[14:0];
      end else if (s1_fire) begin
        st.limit <= st_next.limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      release_mask <= mask_next;
      updated      <= upd;
      active_now   <= st_next.active;
      mode_number  <= num;
      mode_total   <= tot;
      limit_now    <= st_next.limit;
    end
  end

  a_upd_clears_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid && updated |-> acc == '0)
    else $error("updated result but accumulator not cleared");

  a_off_shows_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode_total == 2'd0 |-> mode_number == 2'd0 && !active_now)
    else $error("inactive result shows a preset number");

  a_in_reg_fills: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted word lost before input register");

  a_in_reg_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_kind) && $stable(s1_elapsed))
    else $error("stalled input register changed");

  a_drain_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("processed word did not reach result register");

endmodule

// File: verif/tb_abs_slip_release_controller.sv
// self-checking testbench for the abs slip release controller
`timescale 1ns / 1ps

module tb_abs_slip_release_controller;

  localparam logic [1:0] CHAN_UNUSED = 2'd3;
  localparam logic [20:0] ACC_SAT = 21'h1FFFFF;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic             kind;
    logic [15:0]      elapsed;
    logic [15:0]      speed;
    logic [3:0][15:0] slip;  // fl, fr, rl, rr
    logic             step_up;
  } sensor_word_t;

  typedef struct packed {
    logic [3:0]  mask;
    logic        upd;
    logic        act;
    logic [1:0]  num;
    logic [1:0]  tot;
    logic [14:0] lim;
  } brake_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              kind = 1'b0;
  logic [15:0]       elapsed_us = '0;
  logic [15:0]       speed_q8 = '0;
  logic signed [15:0] slip_front_left = '0;
  logic signed [15:0] slip_front_right = '0;
  logic signed [15:0] slip_rear_left = '0;
  logic signed [15:0] slip_rear_right = '0;
  logic              step_up = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [3:0]        release_mask;
  logic              updated;
  logic              active_now;
  logic [1:0]        mode_number;
  logic [1:0]        mode_total;
  logic [14:0]       limit_now;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [asrc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [asrc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  abs_slip_release_controller uut (.*);

  always #6 clk = ~clk;

  // predictor copy of the registers and state
  logic        unit_on;
  logic [1:0]  chan_sel;
  logic [19:0] period_cfg;
  logic [1:0]  preset_cnt;
  logic [14:0] base_lim;
  logic [14:0] preset_lim [3];
  logic [20:0] accum_us;
  logic        abs_active;
  logic [1:0]  preset_sel;
  logic [14:0] slip_lim;
  logic [3:0]  override_mask;

  sensor_word_t sensor_words_q[$];
  brake_word_t  brake_results_q[$];
  int  queued_count = 0;
  int  fed_count = 0;
  int  stall_cycles = 0;
  bit  failed = 1'b0;
  bit  word_taken = 1'b0;
  bit  cfg_taken = 1'b0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;

  function automatic void write_model_reg(input logic [3:0] idx, input logic [19:0] d);
    case (idx)
      asrc_pkg::REG_UNIT_PRESENT: unit_on = d[0];
      asrc_pkg::REG_CHANNEL_MODE: chan_sel = d[1:0];
      asrc_pkg::REG_PERIOD_US:    period_cfg = d;
      asrc_pkg::REG_PRESET_COUNT: preset_cnt = d[1:0];
      asrc_pkg::REG_BASE_LIMIT: begin
        base_lim = d[14:0];
        slip_lim = d[14:0];
      end
      asrc_pkg::REG_PRESET_0:     preset_lim[0] = d[14:0];
      asrc_pkg::REG_PRESET_1:     preset_lim[1] = d[14:0];
      asrc_pkg::REG_PRESET_2:     preset_lim[2] = d[14:0];
      default: ;
    endcase
  endfunction

  function automatic brake_word_t apply_sensor_word(input sensor_word_t w);
    brake_word_t r;
    logic [21:0] sum;
    logic [3:0]  rel;
    int n;
    int lim;
    r = '0;
    n = (preset_cnt < 2'd3) ? int'(preset_cnt) : 3;
    if (w.kind == asrc_pkg::KIND_CYCLE) begin
      if (unit_on) begin
        if (n == 0) begin
          abs_active = ~abs_active;
        end else if (abs_active) begin
          if (w.step_up) begin
            preset_sel = 2'((int'(preset_sel) + 1) % n);
            if (preset_sel == 2'd0) abs_active = 1'b0;
            else slip_lim = preset_lim[preset_sel];
          end else if (preset_sel == 2'd0) begin
            abs_active = 1'b0;
          end else begin
            preset_sel = preset_sel - 2'd1;
            slip_lim = preset_lim[preset_sel];
          end
        end else begin
          abs_active = 1'b1;
          preset_sel = w.step_up ? 2'd0 : 2'(n - 1);
          slip_lim = preset_lim[preset_sel];
        end
      end
    end else begin
      sum = {1'b0, accum_us} + {6'd0, w.elapsed};
      if (sum > {1'b0, ACC_SAT}) sum = {1'b0, ACC_SAT};
      accum_us = sum[20:0];
      if (sum >= {2'b00, period_cfg}) begin
        r.upd = 1'b1;
        accum_us = '0;
        abs_active = abs_active & unit_on;
        if (abs_active && (int'(w.speed) * 36 > 51200)) begin
          lim = -int'(slip_lim);
          for (int i = 0; i < 4; i++) rel[i] = int'($signed(w.slip[i])) < lim;
          case (chan_sel)
            asrc_pkg::CHAN_ALL:   override_mask = (|rel) ? 4'h0 : 4'hF;
            asrc_pkg::CHAN_PAIRS: override_mask = {(rel[3] | rel[2]) ? 2'b00 : 2'b11,
                                                   (rel[1] | rel[0]) ? 2'b00 : 2'b11};
            asrc_pkg::CHAN_EACH:  override_mask = ~rel;
            default: ;  // unused mode keeps the previous overrides
          endcase
        end else begin
          override_mask = 4'hF;
        end
      end
    end
    if (!abs_active) begin
      r.num = 2'd0;
      r.tot = 2'd0;
    end else if (n == 0) begin
      r.num = 2'd1;
      r.tot = 2'd1;
    end else begin
      r.num = preset_sel + 2'd1;
      r.tot = 2'(n);
    end
    r.mask = override_mask;
    r.act = abs_active;
    r.lim = slip_lim;
    return r;
  endfunction

  // sender
  always @(negedge clk) begin
    sensor_word_t w;
    if (!rst && (!in_valid || word_taken)) begin
      if (sensor_words_q.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
        w = sensor_words_q.pop_front();
        in_valid <= 1'b1;
        kind <= w.kind;
        elapsed_us <= w.elapsed;
        speed_q8 <= w.speed;
        slip_front_left <= w.slip[0];
        slip_front_right <= w.slip[1];
        slip_rear_left <= w.slip[2];
        slip_rear_right <= w.slip[3];
        step_up <= w.step_up;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = 64;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 13);
    end
  end

  // monitor: predict on accepted words, check accepted results
  always @(posedge clk) begin
    sensor_word_t w;
    brake_word_t  e;
    bit busy;
    busy = 1'b0;
    word_taken = 1'b0;
    cfg_taken = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        write_model_reg(cfg_index, cfg_data);
        cfg_taken = 1'b1;
        busy = 1'b1;
      end
      if (in_valid && in_ready) begin
        w.kind = kind;
        w.elapsed = elapsed_us;
        w.speed = speed_q8;
        w.slip[0] = slip_front_left;
        w.slip[1] = slip_front_right;
        w.slip[2] = slip_rear_left;
        w.slip[3] = slip_rear_right;
        w.step_up = step_up;
        brake_results_q.push_back(apply_sensor_word(w));
        fed_count++;
        word_taken = 1'b1;
        busy = 1'b1;
      end
      if (out_valid && out_ready) begin
        busy = 1'b1;
        if (brake_results_q.size() == 0) begin
          $error("result word with no expectation pending");
          failed = 1'b1;
        end else begin
          e = brake_results_q.pop_front();
          if (release_mask !== e.mask) begin
            $error("release_mask: expected %0h, got %0h", e.mask, release_mask);
            failed = 1'b1;
          end
          if (updated !== e.upd) begin
            $error("updated: expected %0d, got %0d", e.upd, updated);
            failed = 1'b1;
          end
          if (active_now !== e.act) begin
            $error("active_now: expected %0d, got %0d", e.act, active_now);
            failed = 1'b1;
          end
          if (mode_number !== e.num) begin
            $error("mode_number: expected %0d, got %0d", e.num, mode_number);
            failed = 1'b1;
          end
          if (mode_total !== e.tot) begin
            $error("mode_total: expected %0d, got %0d", e.tot, mode_total);
            failed = 1'b1;
          end
          if (limit_now !== e.lim) begin
            $error("limit_now: expected %0d, got %0d", e.lim, limit_now);
            failed = 1'b1;
          end
        end
      end
      stall_cycles = busy ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic sensor_word_t tick_word(input int el, input int spd, input int fl,
                                             input int fr, input int rl, input int rr);
    sensor_word_t w;
    w.kind = asrc_pkg::KIND_TICK;
    w.elapsed = 16'(el);
    w.speed = 16'(spd);
    w.slip = {16'(rr), 16'(rl), 16'(fr), 16'(fl)};
    w.step_up = 1'b0;
    return w;
  endfunction

  function automatic sensor_word_t cycle_word(input bit up);
    sensor_word_t w;
    w = sensor_word_t'({$urandom, $urandom, $urandom});
    w.kind = asrc_pkg::KIND_CYCLE;
    w.step_up = up;
    return w;
  endfunction

  function automatic void queue_word(input sensor_word_t w);
    sensor_words_q.push_back(w);
    queued_count++;
  endfunction

  // random word, biased toward updates at speed and slips near the limit
  function automatic sensor_word_t random_word();
    sensor_word_t w;
    int sel;
    int v;
    bit mild;
    w = sensor_word_t'({$urandom, $urandom, $urandom});
    w.kind = ($urandom_range(99) < 15) ? asrc_pkg::KIND_CYCLE : asrc_pkg::KIND_TICK;
    sel = $urandom_range(99);
    if (sel < 5) w.elapsed = 16'd0;
    else if (sel < 10) w.elapsed = 16'hFFFF;
    else if (sel < 25 || period_cfg >= 20'd65535) w.elapsed = 16'($urandom);
    else w.elapsed = 16'($urandom_range(int'(period_cfg)));
    sel = $urandom_range(99);
    if (sel < 10) w.speed = 16'($urandom_range(1422));
    else if (sel < 15) w.speed = 16'($urandom_range(1423, 1422));
    else if (sel < 25) w.speed = 16'($urandom);
    else w.speed = 16'($urandom_range(65535, 1423));
    mild = $urandom_range(99) < 20;
    for (int i = 0; i < 4; i++) begin
      sel = $urandom_range(99);
      if (mild) begin
        w.slip[i] = 16'($urandom_range(32767));
      end else if (sel < 40) begin
        v = -int'(slip_lim) + int'($urandom_range(4)) - 2;
        if (v < -32768) v = -32768;
        w.slip[i] = 16'(v);
      end else if (sel < 45) begin
        w.slip[i] = 16'h8000;
      end else if (sel < 50) begin
        w.slip[i] = 16'h7FFF;
      end
    end
    return w;
  endfunction

  // value with junk above the register width, which must be dropped
  function automatic logic [19:0] with_junk(input int value, input int width);
    logic [19:0] keep;
    keep = 20'((64'd1 << width) - 1);
    return (20'($urandom) & ~keep) | (20'(value) & keep);
  endfunction

  task automatic write_reg(input asrc_pkg::cfg_reg_t idx, input logic [19:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do begin
      @(posedge clk);
      #1;
    end while (!cfg_taken);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    #1;
  endtask

  // test sequence pauses here until every queued word is fed and its result has come back
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (fed_count != queued_count || brake_results_q.size() != 0);
    repeat (4) @(posedge clk);
    #1;
  endtask

  initial begin
    int cnt;
    int per;
    int base_v;
    int present_v;
    unit_on = 1'b1;
    chan_sel = asrc_pkg::CHAN_ALL;
    period_cfg = asrc_pkg::PERIOD_RESET;
    preset_cnt = 2'd0;
    base_lim = asrc_pkg::BASE_LIMIT_RESET;
    for (int i = 0; i < 3; i++) preset_lim[i] = '0;
    accum_us = '0;
    abs_active = 1'b1;
    preset_sel = 2'd0;
    slip_lim = asrc_pkg::BASE_LIMIT_RESET;
    override_mask = 4'hF;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    #1;

    // reset settings: speed threshold, limit edge, slip extremes, on/off toggle
    queue_word(tick_word(0, 0, 0, 0, 0, 0));
    queue_word(tick_word(65535, 1423, -820, 0, 0, 0));
    queue_word(tick_word(65535, 1422, -32768, -32768, -32768, -32768));
    queue_word(tick_word(65535, 65535, -819, 32767, 32767, 32767));
    queue_word(tick_word(65535, 65535, -32768, -32768, -32768, -32768));
    queue_word(cycle_word(1'b1));
    queue_word(tick_word(65535, 65535, -32768, -32768, -32768, -32768));
    queue_word(cycle_word(1'b0));
    wait_drained();

    // zero period, unused channel mode, full preset walk both ways
    write_reg(asrc_pkg::REG_PERIOD_US, 20'd0);
    write_reg(asrc_pkg::REG_CHANNEL_MODE, with_junk(int'(CHAN_UNUSED), 2));
    write_reg(asrc_pkg::REG_PRESET_COUNT, 20'd3);
    write_reg(asrc_pkg::REG_PRESET_0, 20'd0);
    write_reg(asrc_pkg::REG_PRESET_1, 20'd32767);
    write_reg(asrc_pkg::REG_PRESET_2, 20'd100);
    write_reg(asrc_pkg::REG_BASE_LIMIT, 20'd0);
    end_writes();
    queue_word(tick_word(0, 65535, -32768, 0, 0, 0));
    for (int i = 0; i < 3; i++) queue_word(cycle_word(1'b1));
    for (int i = 0; i < 4; i++) queue_word(cycle_word(1'b0));
    for (int i = 0; i < 3; i++) queue_word(cycle_word(1'b1));
    wait_drained();

    // preset count lowered under the selected index
    write_reg(asrc_pkg::REG_PRESET_COUNT, 20'd1);
    write_reg(asrc_pkg::REG_CHANNEL_MODE, 20'(asrc_pkg::CHAN_EACH));
    end_writes();
    queue_word(tick_word(0, 2000, -1, -101, 0, 0));
    queue_word(cycle_word(1'b1));
    queue_word(cycle_word(1'b0));
    queue_word(tick_word(0, 2000, -1, 0, -1, 0));
    wait_drained();

    // unit absent: cycling ignored, update forces inactive
    write_reg(asrc_pkg::REG_UNIT_PRESENT, 20'd0);
    write_reg(asrc_pkg::REG_CHANNEL_MODE, 20'(asrc_pkg::CHAN_PAIRS));
    end_writes();
    queue_word(cycle_word(1'b1));
    queue_word(tick_word(0, 65535, -32768, 0, 0, 0));
    wait_drained();
    write_reg(asrc_pkg::REG_UNIT_PRESENT, 20'd1);
    end_writes();
    queue_word(cycle_word(1'b1));
    queue_word(tick_word(0, 65535, -32768, 0, 0, -32768));
    wait_drained();

    // random phases, each with its own settings
    for (int p = 0; p < 10; p++) begin
      cnt = (p == 1) ? 3 : (p == 2) ? 0 : $urandom_range(3);
      case (p)
        4: per = 0;
        5: per = 1000000;
        6: per = 1;
        7: per = $urandom_range(1048575);
        default: per = $urandom_range(3000, 50);
      endcase
      base_v = (p == 8) ? 32767 : (p == 9) ? 0 : $urandom_range(32767);
      present_v = (p == 3) ? 0 : int'($urandom_range(9) != 0);
      write_reg(asrc_pkg::REG_UNIT_PRESENT, with_junk(present_v, 1));
      write_reg(asrc_pkg::REG_CHANNEL_MODE, with_junk(p % 4, 2));
      write_reg(asrc_pkg::REG_PERIOD_US, 20'(per));
      write_reg(asrc_pkg::REG_PRESET_COUNT, with_junk(cnt, 2));
      write_reg(asrc_pkg::REG_BASE_LIMIT, with_junk(base_v, 15));
      write_reg(asrc_pkg::REG_PRESET_0,
                with_junk((p == 8) ? 32767 : $urandom_range(32767), 15));
      write_reg(asrc_pkg::REG_PRESET_1,
                with_junk((p == 9) ? 0 : $urandom_range(4000), 15));
      write_reg(asrc_pkg::REG_PRESET_2, with_junk($urandom_range(32767), 15));
      end_writes();
      calm = (p == 2);
      for (int i = 0; i < 188; i++) queue_word(random_word());
      if (p == 5) hold_req = 1'b1;
      wait_drained();
    end

    if (failed) begin
      $display("Some tests failed");
    end else begin
      $display("All tests passed");
    end
    $finish;
  end

endmodule
